// ===== sv/frc_pkg.sv =====
// Shared types and constants for the fragment reassembly control block.
// Used by every module of the block; depends on nothing.
package frc_pkg;

    localparam int unsigned FRAGMENT_BYTES = 1024;
    localparam int unsigned MAX_FRAGMENTS  = 64;
    localparam int unsigned HDR_BYTES      = 16;
    localparam logic [7:0]  NO_INDEX       = 8'hff;

    // Largest message that a header may claim, and the bits needed to hold it.
    localparam int unsigned LIMIT_BYTES = MAX_FRAGMENTS * FRAGMENT_BYTES;
    localparam int unsigned TOTAL_W     = $clog2(LIMIT_BYTES + 1);

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        V_REJECT = 2'd0,
        V_ABORT  = 2'd1,
        V_ACCEPT = 2'd2,
        V_DONE   = 2'd3
    } t_verdict;

    // One classified header as it travels from the front to the back.
    typedef struct packed {
        logic               hdr_ok;
        logic               last;
        logic [7:0]         idx;
        logic [TOTAL_W-1:0] total;
        logic [7:0]         cmd;
        logic [10:0]        flen;
    } t_frag;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] write_offset;
        logic [10:0] copy_length;
        logic [7:0]  done_command;
        logic [16:0] done_size;
    } t_result;

endpackage

// ===== sv/frc_front.sv =====
// Front part: takes fragment headers, runs the stateless header checks and
// registers the classified word. Depends on frc_pkg.
module frc_front
    import frc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_total_size,
    input  logic [7:0]  i_inner_command,
    input  logic [7:0]  i_fragment_count,
    input  logic [7:0]  i_fragment_index,
    input  logic [15:0] i_payload_length,
    output logic        o_valid,
    input  logic        i_ready,
    output t_frag       o_frag
);

    logic        r_valid;
    t_frag       r_frag;
    t_frag       n_frag;
    logic [31:0] count_span;
    logic [31:0] prev_span;
    logic [31:0] flen_full;
    logic        last;
    logic        fields_ok;

    always_comb begin
        count_span = 32'(i_fragment_count) * 32'(FRAGMENT_BYTES);
        prev_span  = count_span - 32'(FRAGMENT_BYTES);
        last       = (i_fragment_index == i_fragment_count - 8'd1);
        fields_ok  = (i_total_size != 32'd0) &&
                     (i_total_size <= 32'(LIMIT_BYTES)) &&
                     (i_fragment_count != 8'd0) &&
                     (i_fragment_index < i_fragment_count) &&
                     (i_total_size <= count_span) &&
                     (i_total_size > prev_span);
        // With the size inside the last fragment's span, the remainder is a plain subtract.
        flen_full  = last ? (i_total_size - prev_span) : 32'(FRAGMENT_BYTES);

        n_frag.hdr_ok = fields_ok &&
                        (flen_full + 32'(HDR_BYTES) == 32'(i_payload_length));
        n_frag.last   = last;
        n_frag.idx    = i_fragment_index;
        n_frag.total  = TOTAL_W'(i_total_size);
        n_frag.cmd    = i_inner_command;
        n_frag.flen   = flen_full[10:0];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_frag  = r_frag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_frag <= n_frag;
        end
    end

endmodule

// ===== sv/frc_queue.sv =====
// Short queue of classified headers between the front and the back part.
// Depends on frc_pkg.
module frc_queue
    import frc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_frag i_frag,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_frag o_frag
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_frag                r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [PTR_W:0]       r_count;
    logic                 push_ok;
    logic                 pop_ok;

    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_frag  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_frag;
        end
    end

endmodule

// ===== sv/frc_back.sv =====
// Back part: applies the reassembly state to each classified header and
// holds the result word until it is taken. Depends on frc_pkg.
module frc_back
    import frc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_frag   i_frag,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic               r_active;
    logic [TOTAL_W-1:0] r_expected;
    logic [7:0]         r_prev;
    logic               r_valid;
    t_result            r_result;

    logic               n_active;
    logic [TOTAL_W-1:0] n_expected;
    logic [7:0]         n_prev;
    t_result            n_result;
    logic               start;
    logic               act;
    logic [TOTAL_W-1:0] expd;
    logic [7:0]         prev;
    logic               in_order;

    assign o_pop    = !i_empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        start    = (i_frag.idx == 8'd0);
        act      = start || r_active;
        expd     = start ? i_frag.total : r_expected;
        prev     = start ? NO_INDEX : r_prev;
        in_order = act && (i_frag.total == expd) &&
                   (start || (i_frag.idx == prev + 8'd1));

        n_active   = r_active;
        n_expected = r_expected;
        n_prev     = r_prev;
        n_result   = '0;
        n_result.verdict = V_REJECT;

        if (i_frag.hdr_ok) begin
            if (!in_order) begin
                n_result.verdict = V_ABORT;
                n_active   = 1'b0;
                n_expected = '0;
                n_prev     = NO_INDEX;
            end else begin
                n_result.verdict      = V_ACCEPT;
                n_result.write_offset = 16'(32'(i_frag.idx) * 32'(FRAGMENT_BYTES));
                n_result.copy_length  = i_frag.flen;
                n_active   = 1'b1;
                n_expected = expd;
                n_prev     = i_frag.idx;
                if (i_frag.last) begin
                    n_result.verdict      = V_DONE;
                    n_result.done_command = i_frag.cmd;
                    n_result.done_size    = 17'(i_frag.total);
                    n_active   = 1'b0;
                    n_expected = '0;
                    n_prev     = NO_INDEX;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_expected <= '0;
            r_prev     <= NO_INDEX;
            r_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active   <= n_active;
                r_expected <= n_expected;
                r_prev     <= n_prev;
            end
            if (!r_valid || i_ready) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

// ===== sv/fragment_reassembly_control.sv =====
// Top level of the fragment reassembly control block.
// Depends on frc_pkg, frc_front, frc_queue and frc_back.
//
// Usage: one parsed fragment header is sent as a word on the slave side
// (i_s_*); exactly one result word comes back on the master side (o_m_*),
// in the same order. The result's verdict travels in o_m_tuser: reject,
// abort, accept or complete. For an accepted fragment the data gives the
// write offset and copy length; on completion also the command and size.
// The front register passes each accepted header into the two-entry queue,
// and the back's output register takes it from there as its result word.
// Throughput is one word per cycle while i_m_tready stays high.
// Reset clears the reassembly state (no message in progress), empties the
// queue and drops any pending result. When the receiver holds
// i_m_tready low, the result word holds, the queue fills and then
// o_s_tready falls; o_s_tready never depends on i_m_tready in the same
// cycle.
module fragment_reassembly_control
    import frc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [31:0] total_size, [39:32] inner_command, [47:40] fragment_count,
    // [55:48] fragment_index, [71:56] payload_length
    input  logic [71:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] write_offset, [26:16] copy_length, [34:27] done_command,
    // [51:35] done_size, [55:52] zero
    output logic [55:0] o_m_tdata,
    // [1:0] verdict
    output logic [1:0]  o_m_tuser
);

    logic    front_valid;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    t_frag   front_frag;
    t_frag   q_frag;
    t_result result;

    frc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_total_size     (i_s_tdata[31:0]),
        .i_inner_command  (i_s_tdata[39:32]),
        .i_fragment_count (i_s_tdata[47:40]),
        .i_fragment_index (i_s_tdata[55:48]),
        .i_payload_length (i_s_tdata[71:56]),
        .o_valid          (front_valid),
        .i_ready          (!q_full),
        .o_frag           (front_frag)
    );

    frc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_frag  (front_frag),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_frag  (q_frag)
    );

    frc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_frag   (q_frag),
        .o_pop    (q_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result)
    );

    assign o_m_tuser = result.verdict;
    assign o_m_tdata = {4'd0, result.done_size, result.done_command,
                        result.copy_length, result.write_offset};

    // A result word is never left over from before reset.
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid straight after reset");

    // Only a completed message carries the command and size.
    a_done_fields_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != V_DONE) |->
        (o_m_tdata[51:27] == 25'd0))
        else $error("completion fields set on a word that is not a completion");

    // Rejected or aborted fragments carry no offset and no copy length.
    a_no_copy_unless_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == V_REJECT || o_m_tuser == V_ABORT)) |->
        (o_m_tdata[26:0] == 27'd0))
        else $error("copy fields set on a rejected or aborted fragment");

    // Every accepted fragment copies at least one byte.
    a_accept_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == V_ACCEPT || o_m_tuser == V_DONE)) |->
        (o_m_tdata[26:16] != 11'd0))
        else $error("accepted fragment with zero copy length");

endmodule
